// ===== hdl/hmnmp_pkg.sv =====
// ----------------------------------------------------------------------------
// hmnmp_pkg
// Shared constants for the next-missing-packet selector.
// ----------------------------------------------------------------------------
`default_nettype none

package hmnmp_pkg;

  // default geometry
  localparam int MAP_BYTES_DEF        = 64;
  localparam int WORDS_PER_PACKET_DEF = 63;

  // field widths
  localparam int SW_W    = 15;  // stored_words
  localparam int MBI_W   = 6;   // map_byte_index
  localparam int MBV_W   = 8;   // map_byte_value
  localparam int PIDX_W  = 9;   // packet_index
  localparam int NUM_W   = 16;  // stored_words + divisor - 1
  localparam int DIV_W   = 8;   // divisor width (up to 255)

  // action codes (s_axis_tuser)
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // status codes (m_axis_tuser)
  localparam logic ST_FOUND = 1'b0;
  localparam logic ST_NONE  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/holemap_next_missing_packet.sv =====
// ----------------------------------------------------------------------------
// holemap_next_missing_packet
// Retransmission selector: finds the next missing packet in a received bitmap.
// ----------------------------------------------------------------------------
// A write request (tuser = 0) stores one bitmap byte. A next-packet request
// (tuser = 1) derives the packet total from stored_words with a reciprocal
// multiply, sets up the scan, then scans the bitmap circularly from the start
// pointer, one byte per cycle through the bitmap RAM's read port, waits for
// the last read to return, and then loads the output register. The input is
// therefore not ready from a request until its result is loaded; the scan
// may visit the start byte twice, and a zero total skips it. One result
// (index + status) is returned per next-packet request, none per write. A
// finished result waits in the output register while new requests are taken;
// the next request then holds in its last step until that register is free.
`default_nettype none

module holemap_next_missing_packet
  import hmnmp_pkg::*;
#(
  parameter int MAP_BYTES        = MAP_BYTES_DEF,
  parameter int WORDS_PER_PACKET = WORDS_PER_PACKET_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration: stored_words
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [SW_W-1:0]   cfg_wdata_i,
  // requests
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,  // [5:0] map_byte_index, [13:6] map_byte_value
  input  wire logic              s_axis_tuser,  // [0] action
  // results
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // [8:0] packet_index
  output logic                   m_axis_tuser   // [0] status
);

  localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CAP = MAP_BYTES * 8;
  localparam int TW  = $clog2(CAP + 1);   // packet positions and total
  localparam int BW  = TW - 3;            // byte position
  // floor(n / d) = (n * RECIP) >> RSH, exact for any n below 2**NUM_W
  localparam int     PW    = 2 * NUM_W + 1;
  localparam int     RSH   = NUM_W + $clog2(WORDS_PER_PACKET);
  localparam longint RECIP = (longint'(1) << RSH) / WORDS_PER_PACKET + 1;
  localparam logic [NUM_W-1:0] ROUND  = NUM_W'(WORDS_PER_PACKET - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q;
  logic [SW_W-1:0]   sw_q;
  logic [TW-1:0]     start_q;
  logic [MAP_BYTES-1:0] vld_q;

  // divider
  logic [NUM_W-1:0]  num_q;
  logic [PW-1:0]     prod;
  logic [NUM_W-1:0]  quo;

  // scan
  logic [TW-1:0]     tot_q, s_q;
  logic [BW-1:0]     last0_q, last1_q;
  logic              iss_v_q, iss_ph_q;
  logic [BW-1:0]     iss_b_q;
  logic              chk_v_q, chk_ph_q, chk_last_q;
  logic [BW-1:0]     chk_b_q;

  // result
  logic [PIDX_W-1:0] res_idx_q, m_idx_q;
  logic              res_st_q, m_st_q, m_valid_q;

  // request decode
  logic [MBI_W-1:0]  in_idx;
  logic [MBV_W-1:0]  in_val;
  logic              in_acc, wr_en;

  assign in_idx = s_axis_tdata[MBI_W-1:0];
  assign in_val = s_axis_tdata[MBI_W+MBV_W-1:MBI_W];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wr_en  = in_acc && (s_axis_tuser == ACT_WRITE) &&
                  ({3'b000, in_idx} < 9'(MAP_BYTES));

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(16-PIDX_W){1'b0}}, m_idx_q};
  assign m_axis_tuser  = m_st_q;

  // bitmap memory
  logic [MBV_W-1:0] ram_rdata;

  hmnmp_ram #(
    .WIDTH (MBV_W),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_val),
    .raddr_i (AW'(iss_b_q)),
    .rdata_o (ram_rdata)
  );

  // packet total (rounded up, saturated) and effective start
  logic [TW-1:0] tot_w, s_eff;
  always_comb begin
    prod  = PW'(num_q) * PW'(RECIP);
    quo   = NUM_W'(prod >> RSH);
    tot_w = (quo > NUM_W'(CAP)) ? TW'(CAP) : TW'(quo);
    s_eff = (start_q >= tot_q) ? '0 : start_q;
  end

  // byte check
  logic [MBV_W-1:0] byte_d;
  logic [7:0]       hole;
  logic [2:0]       fb;
  logic [TW-1:0]    lo, hi, pos_i, hit_pos, hit_next, miss_next;
  always_comb begin
    byte_d = vld_q[AW'(chk_b_q)] ? ram_rdata : '0;
    lo     = chk_ph_q ? '0 : s_q;
    hi     = chk_ph_q ? s_q : tot_q;
    hole   = '0;
    fb     = '0;
    for (int i = 0; i < 8; i++) begin
      pos_i   = {chk_b_q, 3'(i)};
      hole[i] = !byte_d[i] && (pos_i >= lo) && (pos_i < hi);
    end
    for (int i = 7; i >= 0; i--) begin
      if (hole[i]) begin
        fb = 3'(i);
      end
    end
    hit_pos   = {chk_b_q, fb};
    hit_next  = hit_pos + TW'(1);
    miss_next = s_q + TW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sw_q       <= '0;
      start_q    <= '0;
      vld_q      <= '0;
      iss_v_q    <= 1'b0;
      chk_v_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sw_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (wr_en) begin
            vld_q[AW'(in_idx)] <= 1'b1;
          end
          if (in_acc && (s_axis_tuser == ACT_REQUEST)) begin
            num_q   <= NUM_W'(sw_q) + ROUND;
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          tot_q   <= tot_w;
          state_q <= S_PREP;
        end

        S_PREP: begin
          s_q     <= s_eff;
          last0_q <= BW'((tot_q - TW'(1)) >> 3);
          last1_q <= BW'((s_eff - TW'(1)) >> 3);
          iss_b_q <= BW'(s_eff >> 3);
          iss_ph_q <= 1'b0;
          chk_v_q <= 1'b0;
          if (tot_q == '0) begin
            res_idx_q <= '0;
            res_st_q  <= ST_NONE;
            start_q   <= '0;
            state_q   <= S_DONE;
          end else begin
            iss_v_q <= 1'b1;
            state_q <= S_SCAN;
          end
        end

        S_SCAN: begin
          // issue side: one byte address per cycle
          chk_v_q    <= iss_v_q;
          chk_b_q    <= iss_b_q;
          chk_ph_q   <= iss_ph_q;
          chk_last_q <= (!iss_ph_q && iss_b_q == last0_q && s_q == '0) ||
                        (iss_ph_q && iss_b_q == last1_q);
          if (iss_v_q) begin
            if (!iss_ph_q && iss_b_q == last0_q) begin
              if (s_q == '0) begin
                iss_v_q <= 1'b0;
              end else begin
                iss_ph_q <= 1'b1;
                iss_b_q  <= '0;
              end
            end else if (iss_ph_q && iss_b_q == last1_q) begin
              iss_v_q <= 1'b0;
            end else begin
              iss_b_q <= iss_b_q + BW'(1);
            end
          end
          // check side: data of the byte issued last cycle
          if (chk_v_q) begin
            if (|hole) begin
              res_idx_q <= PIDX_W'(hit_pos);
              res_st_q  <= ST_FOUND;
              start_q   <= (hit_next >= tot_q) ? '0 : hit_next;
              iss_v_q   <= 1'b0;
              chk_v_q   <= 1'b0;
              state_q   <= S_DONE;
            end else if (chk_last_q) begin
              res_idx_q <= '0;
              res_st_q  <= ST_NONE;
              start_q   <= (miss_next >= tot_q) ? '0 : miss_next;
              iss_v_q   <= 1'b0;
              chk_v_q   <= 1'b0;
              state_q   <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_idx_q   <= res_idx_q;
            m_st_q    <= res_st_q;
            state_q   <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hmnmp_ram.sv =====
// ----------------------------------------------------------------------------
// hmnmp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmnmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== dv/tb_holemap_next_missing_packet.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_holemap_next_missing_packet
// Self-checking bench for the next-missing-packet selector: bitmap writes and
// next-packet requests go in over a stream port, and each result is checked
// against a cycle-free model. Several stored_words settings and three idle mixes
// are used, along with a long output hold-off.
// ----------------------------------------------------------------------------

module tb_holemap_next_missing_packet;
  import hmnmp_pkg::*;

  localparam int MAP_POS      = MAP_BYTES_DEF * 8;
  localparam int SETTLE_CYC   = MAP_BYTES_DEF + 40;
  localparam int RX_HOLD_CYC  = 400;

  typedef struct packed {
    logic             action;
    logic [MBI_W-1:0] byte_idx;
    logic [MBV_W-1:0] byte_val;
  } map_req_t;

  typedef struct packed {
    logic [PIDX_W-1:0] pkt;
    logic              status;
  } pkt_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SW_W-1:0]   cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // [5:0] map_byte_index, [13:6] map_byte_value
  logic              s_axis_tuser = 1'b0; // [0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [8:0] packet_index
  logic              m_axis_tuser;        // [0] status

  holemap_next_missing_packet i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [MBV_W-1:0] rx_map [MAP_BYTES_DEF];
  int               scan_ptr = 0;
  logic [SW_W-1:0]  words_cfg = '0;

  map_req_t    pending_reqs[$];
  pkt_result_t due_results[$];

  bit in_taken = 1'b0;
  int n_errors = 0;
  int tx_idle_pct = 14;
  int rx_idle_pct = 61;
  int stall_tickets = 0;
  int stall_served = 0;
  int rx_hold_left = 0;

  initial begin
    for (int b = 0; b < MAP_BYTES_DEF; b++) rx_map[b] = '0;
  end

  function automatic pkt_result_t next_missing();
    pkt_result_t r;
    int          total;
    int          pos;
    int          nxt;
    bit          hit;
    total = (int'(words_cfg) + WORDS_PER_PACKET_DEF - 1) / WORDS_PER_PACKET_DEF;
    if (total > MAP_POS) total = MAP_POS;
    pos = (scan_ptr >= total) ? 0 : scan_ptr;
    hit = 1'b0;
    r.pkt = '0;
    r.status = ST_NONE;
    for (int n = 0; n < total && !hit; n++) begin
      if (!rx_map[pos / 8][pos % 8]) begin
        hit = 1'b1;
        r.pkt = PIDX_W'(pos);
        r.status = ST_FOUND;
      end else begin
        pos++;
        if (pos >= total) pos = 0;
      end
    end
    // on a miss pos is back at the effective start
    nxt = pos + 1;
    scan_ptr = (nxt >= total) ? 0 : nxt;
    return r;
  endfunction

  // monitor and checker, sampled at the rising edge
  always @(posedge clk_i) begin
    pkt_result_t want;
    in_taken = rst_ni && s_axis_tvalid && (s_axis_tready === 1'b1);
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o === 1'b1) words_cfg = cfg_wdata_i;
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: packet_index %0d status %0d",
                 m_axis_tdata[PIDX_W-1:0], m_axis_tuser);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[PIDX_W-1:0] !== want.pkt) begin
            $error("packet_index: expected %0d, got %0d", want.pkt, m_axis_tdata[PIDX_W-1:0]);
            n_errors++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            n_errors++;
          end
        end
      end
      if (in_taken) begin
        if (s_axis_tuser == ACT_WRITE)
          rx_map[s_axis_tdata[MBI_W-1:0]] = s_axis_tdata[MBI_W +: MBV_W];
        else
          due_results.push_back(next_missing());
      end
    end
  end

  // request driver, falling edge
  always @(negedge clk_i) begin
    bit offer;
    if (in_taken) void'(pending_reqs.pop_front());
    offer = s_axis_tvalid && !in_taken;
    if (!offer && pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) offer = 1'b1;
    s_axis_tvalid <= offer;
    if (offer) begin
      s_axis_tuser <= pending_reqs[0].action;
      s_axis_tdata <= {2'b00, pending_reqs[0].byte_val, pending_reqs[0].byte_idx};
    end
  end

  // result receiver; a stall ticket buys one long hold-off
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left = rx_hold_left - 1;
    end else if (stall_served != stall_tickets) begin
      rx_hold_left = RX_HOLD_CYC;
      stall_served = stall_served + 1;
    end
    m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic queue_write(input int idx, input int val);
    pending_reqs.push_back('{ACT_WRITE, MBI_W'(idx), MBV_W'(val)});
  endtask

  task automatic queue_request();
    pending_reqs.push_back('{ACT_REQUEST, MBI_W'(0), MBV_W'(0)});
  endtask

  task automatic wait_results();
    while (pending_reqs.size() != 0 || due_results.size() != 0) @(posedge clk_i);
  endtask

  // writes only take place once the block has gone idle
  task automatic set_words(input int w);
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= SW_W'(w);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_random_items(input int count);
    int total;
    int nbytes;
    int k;
    int pick;
    int idx;
    int val;
    total = (int'(words_cfg) + WORDS_PER_PACKET_DEF - 1) / WORDS_PER_PACKET_DEF;
    if (total > MAP_POS) total = MAP_POS;
    nbytes = (total + 7) / 8;
    if (nbytes == 0) nbytes = 1;
    k = 0;
    while (k < count) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        // fill the live range, optionally punch one hole, then ask repeatedly
        for (int b = 0; b < nbytes; b++) queue_write(b, 8'hFF);
        k += nbytes;
        if ($urandom_range(1)) begin
          queue_write($urandom_range(nbytes - 1), 8'hFF ^ (8'h01 << $urandom_range(7)));
          k++;
        end
        repeat (3) queue_request();
        k += 3;
      end else if (pick < 52) begin
        queue_request();
        k++;
      end else begin
        idx = ($urandom_range(4) != 0) ? $urandom_range(nbytes - 1) : $urandom_range(63);
        case ($urandom_range(3))
          0:       val = 8'hFF;
          1:       val = 8'hFF ^ (8'h01 << $urandom_range(7));
          default: val = $urandom_range(255);
        endcase
        queue_write(idx, val);
        k++;
      end
    end
  endtask

  initial begin
    int seg_words[9];
    int w;
    seg_words = '{200, 32767, 0, 16384, 126, 4000, 32193, 700, 63};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero total straight out of reset
    queue_request();
    queue_write(63, 8'hFF);
    queue_request();
    // one packet
    set_words(1);
    queue_request();
    queue_write(0, 8'h01);
    queue_request();
    // two packets: hit on the last position wraps the pointer
    set_words(126);
    queue_request();
    queue_request();
    queue_write(0, 8'h03);
    queue_request();
    queue_request();
    // total saturates at the bitmap size
    set_words(32767);
    queue_request();
    queue_write(63, 8'h7F);
    queue_write(0, 8'hFF);
    queue_request();
    // pointer beyond the new total wraps to zero
    set_words(64);
    queue_request();
    set_words(16384);
    queue_write(32, 8'hEF);
    queue_request();
    queue_write(0, 8'h00);
    queue_request();

    for (int seg = 0; seg < 9; seg++) begin
      w = (seg == 5 || seg == 7) ? $urandom_range(32767) : seg_words[seg];
      set_words(w);
      case (seg / 3)
        0:       begin tx_idle_pct = 14; rx_idle_pct = 61; end
        1:       begin tx_idle_pct = 61; rx_idle_pct = 14; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      if (seg == 0) begin
        // hold the output off while requests keep coming
        stall_tickets++;
        repeat (30) queue_request();
      end
      add_random_items(50);
      wait_results();
      add_random_items(50);
    end

    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
